### hw/rtl/ale_pkg.sv
package ale_pkg;

    // field and port widths
    localparam int CHAR_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int STEP_W      = 3;

    // default depth of the queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LABEL_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_URL_MODE     = 2'd1;

    // character constants
    localparam logic [CHAR_W-1:0] CH_PREFIX     = 8'h4C; // 'L'
    localparam logic [CHAR_W-1:0] CH_DASH       = 8'h2D; // '-'
    localparam logic [CHAR_W-1:0] CH_PERCENT    = 8'h25; // '%'
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F; // '_'
    localparam logic [CHAR_W-1:0] CH_COLON      = 8'h3A; // ':'
    localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E; // '.'
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20; // ' '

    // what the back end does with one byte
    typedef enum logic [1:0] {
        OP_COPY,
        OP_DASH,
        OP_ESC
    } op_kind_t;

    // one classified byte, as it travels through the queue
    typedef struct packed {
        logic              prefix;
        op_kind_t          kind;
        logic              html5;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } op_t;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // lower-case hex digit for one nibble
    function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib);
        logic [CHAR_W-1:0] wide;
        wide = {4'b0000, nib};
        if (nib < 4'd10)
            return 8'h30 + wide;
        else
            return 8'h57 + wide;
    endfunction

endpackage

### hw/rtl/ale_front.sv
module ale_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ale_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic                                cfg_data,
    // input beats
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ale_pkg::CHAR_W-1:0]          in_char,
    input  logic                                label_first,
    input  logic                                label_last,
    // queue side
    input  ale_pkg::queue_status_t              q_status,
    output logic                                push,
    output ale_pkg::op_t                        push_op
);

    logic label_format_reg;
    logic label_format_next;
    logic url_mode_reg;
    logic url_mode_next;

    logic is_letter;
    logic is_digit;
    logic is_white;
    logic pass;
    logic html5;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        label_format_next = label_format_reg;
        url_mode_next     = url_mode_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ale_pkg::CFG_LABEL_FORMAT: label_format_next = cfg_data;
                ale_pkg::CFG_URL_MODE:     url_mode_next     = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_format_reg <= 1'b1;
            url_mode_reg     <= 1'b0;
        end
        else
        begin
            label_format_reg <= label_format_next;
            url_mode_reg     <= url_mode_next;
        end
    end

    // c locale character classes
    assign is_letter = (in_char >= 8'h41 && in_char <= 8'h5A) ||
                       (in_char >= 8'h61 && in_char <= 8'h7A);
    assign is_digit  = in_char >= 8'h30 && in_char <= 8'h39;
    assign is_white  = in_char == ale_pkg::CH_SPACE ||
                       (in_char >= 8'h09 && in_char <= 8'h0D);
    assign html5     = !url_mode_reg;

    assign pass = html5
        ? (is_letter || is_digit || in_char == ale_pkg::CH_UNDERSCORE ||
           in_char == ale_pkg::CH_COLON || in_char == ale_pkg::CH_DOT)
        : !(is_white || in_char == ale_pkg::CH_PERCENT);

    // classify the beat into one queue entry
    always_comb
    begin
        push_op.prefix = label_format_reg && html5 && label_first && !is_letter;
        push_op.html5  = html5;
        push_op.ch     = in_char;
        push_op.last   = label_last;
        if (!label_format_reg || pass)
            push_op.kind = ale_pkg::OP_COPY;
        else if (in_char == ale_pkg::CH_SPACE)
            push_op.kind = ale_pkg::OP_DASH;
        else
            push_op.kind = ale_pkg::OP_ESC;
    end

    // take a beat whenever the queue has room
    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

endmodule

### hw/rtl/ale_queue.sv
module ale_queue
#(
    parameter int DEPTH = ale_pkg::QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ale_pkg::op_t           push_op,
    input  logic                   pop,
    output ale_pkg::op_t           head_op,
    output ale_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ale_pkg::op_t     entry_reg [DEPTH];
    logic [PTR_W:0]   wr_ptr_reg;
    logic [PTR_W:0]   wr_ptr_next;
    logic [PTR_W:0]   rd_ptr_reg;
    logic [PTR_W:0]   rd_ptr_next;

    // full when pointers differ only in the wrap bit
    assign status.empty = wr_ptr_reg == rd_ptr_reg;
    assign status.full  = (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]) &&
                          (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]);

    assign head_op     = entry_reg[rd_ptr_reg[PTR_W-1:0]];
    assign wr_ptr_next = wr_ptr_reg + (PTR_W+1)'(1);
    assign rd_ptr_next = rd_ptr_reg + (PTR_W+1)'(1);

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg[PTR_W-1:0]] <= push_op;
    end

endmodule

### hw/rtl/ale_back.sv
module ale_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    // queue side
    input  ale_pkg::queue_status_t     q_status,
    input  ale_pkg::op_t               head_op,
    output logic                       pop,
    // output beats
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ale_pkg::CHAR_W-1:0] out_char,
    output logic                       run_last,
    output logic                       label_end
);

    localparam int SW = ale_pkg::STEP_W;

    logic [SW-1:0]              step_reg;
    logic [SW-1:0]              step_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [ale_pkg::CHAR_W-1:0] out_char_reg;
    logic                       run_last_reg;
    logic                       label_end_reg;

    logic [SW-1:0]              body_step;
    logic [SW-1:0]              run_len;
    logic                       last_byte;
    logic                       load;
    logic [ale_pkg::CHAR_W-1:0] byte_sel;

    // length of the run for the head entry
    always_comb
    begin
        unique case (head_op.kind)
            ale_pkg::OP_COPY: run_len = SW'(1);
            ale_pkg::OP_DASH: run_len = SW'(1);
            ale_pkg::OP_ESC:  run_len = head_op.html5 ? SW'(4) : SW'(3);
            default:          run_len = SW'(1);
        endcase
        run_len = run_len + SW'(head_op.prefix);
    end

    assign body_step = step_reg - SW'(head_op.prefix);
    assign last_byte = step_reg == run_len - SW'(1);

    // pick the byte for this step
    always_comb
    begin
        byte_sel = head_op.ch;
        if (head_op.prefix && step_reg == '0)
            byte_sel = ale_pkg::CH_PREFIX;
        else
        begin
            unique case (head_op.kind)
                ale_pkg::OP_COPY: byte_sel = head_op.ch;
                ale_pkg::OP_DASH: byte_sel = ale_pkg::CH_DASH;
                ale_pkg::OP_ESC:
                begin
                    case (body_step)
                        SW'(0):  byte_sel = head_op.html5 ? ale_pkg::CH_DASH
                                                          : ale_pkg::CH_PERCENT;
                        SW'(1):  byte_sel = ale_pkg::hex_digit(head_op.ch[7:4]);
                        SW'(2):  byte_sel = ale_pkg::hex_digit(head_op.ch[3:0]);
                        default: byte_sel = ale_pkg::CH_DASH;
                    endcase
                end
                default: byte_sel = head_op.ch;
            endcase
        end
    end

    // load the output register when it is free or being taken
    assign load           = !q_status.empty && (!out_valid_reg || !out_stall);
    assign pop            = load && last_byte;
    assign step_next      = last_byte ? '0 : step_reg + SW'(1);
    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
                step_reg <= step_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg  <= byte_sel;
            run_last_reg  <= last_byte;
            label_end_reg <= last_byte && head_op.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign run_last  = run_last_reg;
    assign label_end = label_end_reg;

endmodule

### hw/rtl/anchor_label_encoder_core.sv
// Anchor label encoder: takes one label byte per beat and gives its anchor text one
// byte per beat. A byte gives one output beat when copied or turned into a dash, three
// for a url percent escape, four for an html5 dash-hex escape, plus one for the 'L'
// prefix in html5 label format on a label that does not open with a letter, so 1 to 5
// output bytes per input byte. The back end emits exactly one byte per cycle while
// out_stall is low, from the head of a small queue (DEPTH entries, a power of two of at
// least 2), and that output loop sets the sustained rate. The front end takes a new
// byte in every cycle while the queue has room, and the queue keeps taking bytes while
// an output beat waits. Configuration takes effect for bytes accepted after the write.
module anchor_label_encoder_core
#(
    parameter int DEPTH = ale_pkg::QUEUE_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ale_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                            cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ale_pkg::CHAR_W-1:0]      in_char,
    input  logic                            label_first,
    input  logic                            label_last,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ale_pkg::CHAR_W-1:0]      out_char,
    output logic                            run_last,
    output logic                            label_end
);

    ale_pkg::queue_status_t q_status;
    ale_pkg::op_t           push_op;
    ale_pkg::op_t           head_op;
    logic                   push;
    logic                   pop;

    // front end: configuration and classification
    ale_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_char     (in_char),
        .label_first (label_first),
        .label_last  (label_last),
        .q_status    (q_status),
        .push        (push),
        .push_op     (push_op)
    );

    // queue between front and back
    ale_queue #(.DEPTH(DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_status)
    );

    // back end: byte sequencer and output register
    ale_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_op   (head_op),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .run_last  (run_last),
        .label_end (label_end)
    );

    // end of label only closes a run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && label_end |-> run_last)
        else $error("label end without run end");

    // queue is never both full and empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");

    // a run in progress keeps the output busy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid)
        else $error("gap inside an escape run");

    // nothing is popped from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

### sim/tb_top.sv
module tb_top;

    localparam int N_RANDOM   = 450;
    localparam int DRAIN_PAD  = 12;
    localparam int CYCLE_CAP  = 400000;

    // one output beat as the encoder should produce it
    typedef struct {
        logic [ale_pkg::CHAR_W-1:0] ch;
        logic                       run_last;
        logic                       label_end;
    } anchor_beat_t;

    // one directed stimulus row, n_known = 0 means the predictor supplies the result
    typedef struct {
        logic                       fmt;
        logic                       url;
        logic [ale_pkg::CHAR_W-1:0] ch;
        logic                       first;
        logic                       last;
        int                         n_known;
        logic [39:0]                known;
    } label_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ale_pkg::CFG_INDEX_W-1:0] cfg_index = ale_pkg::CFG_LABEL_FORMAT;
    logic                            cfg_data = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [ale_pkg::CHAR_W-1:0]      in_char = '0;
    logic                            label_first = 1'b0;
    logic                            label_last = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [ale_pkg::CHAR_W-1:0]      out_char;
    logic                            run_last;
    logic                            label_end;

    // encoder settings as the testbench believes them
    logic fmt_on = 1'b1;
    logic url_on = 1'b0;

    anchor_beat_t pending_beats[$];
    label_row_t   label_rows[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           rx_wait = 0;
    bit           rx_quiet = 1'b0;
    bit           tx_quiet = 1'b0;

    anchor_label_encoder_core u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_char     (in_char),
        .label_first (label_first),
        .label_last  (label_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .run_last    (run_last),
        .label_end   (label_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // c locale character classes
    function automatic bit is_alpha_byte(input logic [ale_pkg::CHAR_W-1:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_num_byte(input logic [ale_pkg::CHAR_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank_byte(input logic [ale_pkg::CHAR_W-1:0] c);
        return c == ale_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [ale_pkg::CHAR_W-1:0] nibble_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h61 + {4'h0, nib} - 8'd10);
    endfunction

    // anchor encoding of one byte, first output byte in seq[7:0]
    function automatic int encode_byte(input logic [ale_pkg::CHAR_W-1:0] c,
                                       input logic first,
                                       output logic [39:0] seq);
        int  n;
        bit  html5;
        bit  pass;
        n = 0;
        seq = '0;
        html5 = !url_on;
        if (fmt_on && html5 && first && !is_alpha_byte(c))
        begin
            seq[8*n +: 8] = ale_pkg::CH_PREFIX;
            n++;
        end
        if (!fmt_on)
        begin
            seq[8*n +: 8] = c;
            n++;
        end
        else
        begin
            if (html5)
                pass = is_alpha_byte(c) || is_num_byte(c) || c == ale_pkg::CH_UNDERSCORE
                       || c == ale_pkg::CH_COLON || c == ale_pkg::CH_DOT;
            else
                pass = !(is_blank_byte(c) || c == ale_pkg::CH_PERCENT);
            if (pass)
            begin
                seq[8*n +: 8] = c;
                n++;
            end
            else if (c == ale_pkg::CH_SPACE)
            begin
                seq[8*n +: 8] = ale_pkg::CH_DASH;
                n++;
            end
            else
            begin
                seq[8*n +: 8] = html5 ? ale_pkg::CH_DASH : ale_pkg::CH_PERCENT;
                seq[8*(n+1) +: 8] = nibble_char(c[7:4]);
                seq[8*(n+2) +: 8] = nibble_char(c[3:0]);
                n += 3;
                if (html5)
                begin
                    seq[8*n +: 8] = ale_pkg::CH_DASH;
                    n++;
                end
            end
        end
        return n;
    endfunction

    // queue the beats one accepted byte should produce
    function automatic void queue_anchor_beats(input logic [ale_pkg::CHAR_W-1:0] c,
                                               input logic first,
                                               input logic last, input int n_known,
                                               input logic [39:0] known);
        logic [39:0]  seq;
        int           n;
        anchor_beat_t b;
        if (n_known > 0)
        begin
            // typed-in text reads left to right, so reverse it into seq order
            n = n_known;
            for (int k = 0; k < n; k++)
                seq[8*k +: 8] = known[8*(n-1-k) +: 8];
        end
        else
            n = encode_byte(c, first, seq);
        for (int k = 0; k < n; k++)
        begin
            b.ch = seq[8*k +: 8];
            b.run_last = (k == n - 1);
            b.label_end = (k == n - 1) && last;
            pending_beats.push_back(b);
        end
    endfunction

    // drive one input beat after a gap, wait for acceptance
    task automatic send_byte(input logic [ale_pkg::CHAR_W-1:0] c, input logic first,
                             input logic last, input int n_known,
                             input logic [39:0] known);
        int gap;
        gap = tx_quiet ? 0 : int'($urandom_range(0, 14));
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_char <= c;
        label_first <= first;
        label_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        queue_anchor_beats(c, first, last, n_known, known);
    endtask

    // stop sending and let every outstanding beat come out
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // write both registers, block must be idle
    task automatic apply_mode(input logic fmt, input logic url);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= ale_pkg::CFG_LABEL_FORMAT;
        cfg_data <= fmt;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        fmt_on = fmt;
        @(negedge clk);
        cfg_index <= ale_pkg::CFG_URL_MODE;
        cfg_data <= url;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        url_on = url;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly interesting bytes, some anywhere in the range
    function automatic logic [ale_pkg::CHAR_W-1:0] pick_label_byte();
        logic [ale_pkg::CHAR_W-1:0] specials [5];
        specials = '{ale_pkg::CH_UNDERSCORE, ale_pkg::CH_COLON, ale_pkg::CH_DOT,
                     ale_pkg::CH_PERCENT, ale_pkg::CH_DASH};
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(0, 255));
            3:       return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
            4:       return 8'(8'h30 + $urandom_range(0, 9));
            5:       return $urandom_range(0, 5) == 0 ? ale_pkg::CH_SPACE
                                                      : 8'(8'h09 + $urandom_range(0, 4));
            6:       return specials[$urandom_range(0, 4)];
            7:       return ale_pkg::CH_SPACE;
            8:       return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(33, 126));
        endcase
    endfunction

    // output checker
    always @(posedge clk)
    begin
        anchor_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                mismatch_count++;
                $error("unexpected output beat: out_char %02h", out_char);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (out_char !== want.ch)
                begin
                    mismatch_count++;
                    $error("out_char: expected %02h, got %02h", want.ch, out_char);
                end
                if (run_last !== want.run_last)
                begin
                    mismatch_count++;
                    $error("run_last: expected %0b, got %0b", want.run_last, run_last);
                end
                if (label_end !== want.label_end)
                begin
                    mismatch_count++;
                    $error("label_end: expected %0b, got %0b", want.label_end, label_end);
                end
            end
            if (label_end && $urandom_range(0, 7) == 0)
                rx_quiet = !rx_quiet;
            rx_wait = rx_quiet ? 0 : int'($urandom_range(0, 14));
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (rx_wait > 0)
        begin
            out_stall <= 1'b1;
            rx_wait--;
        end
        else
            out_stall <= 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int  sent;
        int  since_mode;
        int  mode_span;
        int  len;
        bit  well_formed;
        bit  mid_pause_done;
        logic nf;
        logic nu;
        logic [ale_pkg::CHAR_W-1:0] c;

        // directed rows: html5 mode after reset, then url, then copy
        label_rows.push_back('{1'b1, 1'b0, "A",        1'b1, 1'b0, 1, "A"});
        label_rows.push_back('{1'b1, 1'b0, ale_pkg::CH_UNDERSCORE, 1'b0, 1'b0, 0, '0});
        label_rows.push_back('{1'b1, 1'b0, ale_pkg::CH_COLON,   1'b0, 1'b0, 0, '0});
        label_rows.push_back('{1'b1, 1'b0, ale_pkg::CH_DOT,     1'b0, 1'b0, 0, '0});
        label_rows.push_back('{1'b1, 1'b0, "9",        1'b0, 1'b0, 0, '0});
        label_rows.push_back('{1'b1, 1'b0, ale_pkg::CH_SPACE,   1'b0, 1'b0, 0, '0});
        label_rows.push_back('{1'b1, 1'b0, "/",        1'b0, 1'b0, 0, '0});
        label_rows.push_back('{1'b1, 1'b0, "z",        1'b0, 1'b1, 0, '0});
        label_rows.push_back('{1'b1, 1'b0, 8'h00,      1'b1, 1'b1, 5, "L-00-"});
        label_rows.push_back('{1'b1, 1'b0, 8'hFF,      1'b0, 1'b1, 4, "-ff-"});
        label_rows.push_back('{1'b1, 1'b0, ale_pkg::CH_SPACE,   1'b1, 1'b1, 2, "L-"});
        label_rows.push_back('{1'b1, 1'b0, "5",        1'b1, 1'b0, 0, '0});
        label_rows.push_back('{1'b1, 1'b0, 8'h80,      1'b0, 1'b0, 0, '0});
        label_rows.push_back('{1'b1, 1'b1, ale_pkg::CH_PERCENT, 1'b1, 1'b0, 3, "%25"});
        label_rows.push_back('{1'b1, 1'b1, 8'h09,      1'b0, 1'b0, 0, '0});
        label_rows.push_back('{1'b1, 1'b1, 8'h0D,      1'b0, 1'b1, 0, '0});
        label_rows.push_back('{1'b1, 1'b1, ale_pkg::CH_SPACE,   1'b1, 1'b0, 0, '0});
        label_rows.push_back('{1'b1, 1'b1, 8'h00,      1'b1, 1'b1, 1, 40'h00});
        label_rows.push_back('{1'b1, 1'b1, 8'hFF,      1'b0, 1'b1, 1, 40'hFF});
        label_rows.push_back('{1'b1, 1'b1, ale_pkg::CH_DOT,     1'b0, 1'b0, 0, '0});
        label_rows.push_back('{1'b0, 1'b0, 8'h00,      1'b1, 1'b1, 1, 40'h00});
        label_rows.push_back('{1'b0, 1'b0, 8'hFF,      1'b0, 1'b0, 1, 40'hFF});
        label_rows.push_back('{1'b0, 1'b0, ale_pkg::CH_SPACE,   1'b0, 1'b0, 0, '0});
        label_rows.push_back('{1'b0, 1'b1, ale_pkg::CH_PERCENT, 1'b1, 1'b1, 0, '0});

        // reset
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part
        foreach (label_rows[i])
        begin
            if (label_rows[i].fmt !== fmt_on || label_rows[i].url !== url_on)
            begin
                wait_for_drain();
                apply_mode(label_rows[i].fmt, label_rows[i].url);
            end
            send_byte(label_rows[i].ch, label_rows[i].first, label_rows[i].last,
                      label_rows[i].n_known, label_rows[i].known);
        end

        // random labels, settings change between phases
        sent = 0;
        since_mode = 0;
        mode_span = $urandom_range(30, 80);
        mid_pause_done = 1'b0;
        while (sent < N_RANDOM)
        begin
            if (since_mode >= mode_span)
            begin
                nf = ($urandom_range(0, 3) != 0);
                nu = 1'($urandom_range(0, 1));
                wait_for_drain();
                apply_mode(nf, nu);
                since_mode = 0;
                mode_span = $urandom_range(30, 80);
            end
            else if ((!mid_pause_done && sent >= N_RANDOM / 2) || $urandom_range(0, 24) == 0)
            begin
                // sender holds off until the pipe is empty
                wait_for_drain();
                mid_pause_done = 1'b1;
            end
            if ($urandom_range(0, 6) == 0)
                tx_quiet = !tx_quiet;
            len = $urandom_range(1, 12);
            well_formed = ($urandom_range(0, 99) < 85);
            for (int k = 0; k < len; k++)
            begin
                c = pick_label_byte();
                if (well_formed)
                    send_byte(c, k == 0, k == len - 1, 0, '0);
                else
                    send_byte(c, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0, '0);
            end
            sent += len;
            since_mode += len;
        end

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (pending_beats.size() != 0)
        begin
            mismatch_count++;
            $error("%0d output beats never arrived", pending_beats.size());
        end

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
